FILE: sv/edge_triggered_one_shot_macros.svh
// assertion helpers for the one-shot block
`ifndef EDGE_TRIGGERED_ONE_SHOT_MACROS_SVH
`define EDGE_TRIGGERED_ONE_SHOT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define ETO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eto assertion failed");

// next-cycle implication, checked out of reset
`define ETO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eto assertion failed");

`else

`define ETO_ASSERT_IMP(lbl, ante, cons)
`define ETO_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: sv/eto_pkg.sv
package eto_pkg;

  localparam int CFG_W = 16;

  // register indexes
  localparam logic [1:0] REG_TRIGGER_MODE   = 2'd0;
  localparam logic [1:0] REG_PULSE_TICKS    = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE_TICKS = 2'd2;
  localparam logic [1:0] REG_IDLE_HIGH      = 2'd3;

  // trigger modes
  localparam logic [1:0] MODE_EITHER = 2'd0;
  localparam logic [1:0] MODE_RISE   = 2'd1;
  localparam logic [1:0] MODE_FALL   = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_PULSE = 3'b010,
    PH_HOLD  = 3'b100
  } eto_phase_t;

  typedef struct packed {
    logic [1:0]       trigger_mode;
    logic [CFG_W-1:0] pulse_ticks;
    logic [CFG_W-1:0] debounce_ticks;
    logic             idle_high;
  } eto_cfg_t;

  typedef struct packed {
    logic level;
    logic busy;
  } eto_res_t;

endpackage

FILE: sv/edge_triggered_one_shot.sv
// edge triggered one-shot with debounce hold-off, one word in and one word out per sample tick
// path: an accepted word goes into the input register, and its result into the result register
// throughput: one word per cycle while out_ready holds; the input register takes a new word while a result waits
// reset: rst_n synchronous active low; state idle, latch and pending clear, registers at defaults
// registers after reset: rising edge, 100 tick pulse, 50 tick hold-off, output rests low
`include "edge_triggered_one_shot_macros.svh"

module edge_triggered_one_shot
  import eto_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // sample word in
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_pin_level,
  // result word out
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_level,
  output logic             out_busy_res,
  // register writes
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  eto_cfg_t cfg;
  eto_res_t res;

  logic s1_valid_r;
  logic s1_pin_r;
  logic out_valid_r;
  logic out_level_r;
  logic out_busy_r;
  logic advance;

  eto_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // the sample word in the input register is processed when the result register can take it;
  // state in the core moves only then, so a stalled output never loses or repeats a tick
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  eto_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .pin   (s1_pin_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pin_r <= in_pin_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level_r <= res.level;
      out_busy_r  <= res.busy;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_level    = out_level_r;
  assign out_busy_res = out_busy_r;

  // an idle result shows the rest level
  `ETO_ASSERT_IMP(a_rest_level, out_valid_r && !out_busy_r, out_level_r == cfg.idle_high)
  // a processed word always lands in the result register
  `ETO_ASSERT_NXT(a_advance_lands, advance, out_valid_r)
  // a word waiting in the input register is kept until processed
  `ETO_ASSERT_NXT(a_s1_hold, s1_valid_r && !advance, s1_valid_r && $stable(s1_pin_r))

endmodule

FILE: sv/eto_cfg_regs.sv
module eto_cfg_regs
  import eto_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output eto_cfg_t         cfg
);

  eto_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_mode   <= MODE_RISE;
      cfg_r.pulse_ticks    <= CFG_W'(100);
      cfg_r.debounce_ticks <= CFG_W'(50);
      cfg_r.idle_high      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIGGER_MODE:   cfg_r.trigger_mode   <= cfg_wdata[1:0];
        REG_PULSE_TICKS:    cfg_r.pulse_ticks    <= cfg_wdata;
        REG_DEBOUNCE_TICKS: cfg_r.debounce_ticks <= cfg_wdata;
        REG_IDLE_HIGH:      cfg_r.idle_high      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/eto_core.sv
module eto_core
  import eto_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  logic     pin,
  input  eto_cfg_t cfg,
  output eto_res_t res
);

  localparam logic [31:0] CntMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic                   last_level_r;
  logic                   edge_latch_r;
  logic                   pend_r;
  eto_phase_t             phase_r;
  logic [COUNT_WIDTH-1:0] cnt_r;

  logic                   latch_nxt;
  logic                   pend_nxt;
  eto_phase_t             phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_nxt;

  logic                   change;
  logic                   active;
  logic                   fire;
  eto_phase_t             ph_j;
  logic [COUNT_WIDTH-1:0] cnt_j;
  logic [COUNT_WIDTH-1:0] cnt_dec;
  logic [31:0]            pulse32;
  logic [31:0]            hold32;
  logic [COUNT_WIDTH-1:0] pulse_sat;
  logic [COUNT_WIDTH-1:0] pulse_ld;
  logic [COUNT_WIDTH-1:0] hold_ld;

  // lengths saturate to the counter, zero pulse acts as one
  assign pulse32   = {{(32-CFG_W){1'b0}}, cfg.pulse_ticks};
  assign hold32    = {{(32-CFG_W){1'b0}}, cfg.debounce_ticks};
  assign pulse_sat = (pulse32 > CntMax) ? CntMax[COUNT_WIDTH-1:0] : pulse32[COUNT_WIDTH-1:0];
  assign pulse_ld  = (pulse_sat == '0) ? COUNT_WIDTH'(1) : pulse_sat;
  assign hold_ld   = (hold32 > CntMax) ? CntMax[COUNT_WIDTH-1:0] : hold32[COUNT_WIDTH-1:0];

  assign change = pin ^ last_level_r;

  always_comb begin
    ph_j      = phase_r;
    cnt_j     = cnt_r;
    latch_nxt = edge_latch_r;
    pend_nxt  = pend_r;
    fire      = 1'b0;
    active    = (cfg.trigger_mode == MODE_RISE) ? pin : ~pin;

    if (phase_r == PH_IDLE) begin
      if (change || pend_r) begin
        pend_nxt = 1'b0;
        case (cfg.trigger_mode)
          MODE_EITHER: fire = 1'b1;
          MODE_RISE, MODE_FALL: begin
            if (active && !edge_latch_r) begin
              fire      = 1'b1;
              latch_nxt = 1'b1;
            end else if (!active) begin
              latch_nxt = 1'b0;
            end
          end
          default: ;
        endcase
        if (fire) begin
          ph_j  = PH_PULSE;
          cnt_j = pulse_ld;
        end else if (hold_ld == '0) begin
          ph_j  = PH_IDLE;
          cnt_j = '0;
        end else begin
          ph_j  = PH_HOLD;
          cnt_j = hold_ld;
        end
      end
    end else if (change) begin
      pend_nxt = 1'b1;
    end

    res.level = (ph_j == PH_PULSE) ^ cfg.idle_high;
    res.busy  = (ph_j != PH_IDLE);

    cnt_dec = cnt_j - COUNT_WIDTH'(1);
    case (ph_j)
      PH_PULSE: begin
        if (cnt_dec != '0) begin
          phase_nxt = PH_PULSE;
          cnt_nxt   = cnt_dec;
        end else if (hold_ld == '0) begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
        end else begin
          phase_nxt = PH_HOLD;
          cnt_nxt   = hold_ld;
        end
      end
      PH_HOLD: begin
        cnt_nxt   = cnt_dec;
        phase_nxt = (cnt_dec == '0) ? PH_IDLE : PH_HOLD;
      end
      default: begin
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      edge_latch_r <= 1'b0;
      pend_r       <= 1'b0;
      phase_r      <= PH_IDLE;
      cnt_r        <= '0;
    end else if (step) begin
      last_level_r <= pin;
      edge_latch_r <= latch_nxt;
      pend_r       <= pend_nxt;
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

endmodule
